// ===== hw/rtl/vpr_pkg.sv =====
`default_nettype none

package vpr_pkg;

	localparam int CHANNELS    = 3;
	localparam int MAX_DIM     = 4096;
	localparam int MAX_PATCH   = 64;
	localparam int MAX_COPIES  = 4;
	localparam int MERGE_LIMIT = 8;

	localparam int DIM_W   = 13;
	localparam int PATCH_W = 7;
	localparam int MERGE_W = 4;
	localparam int COPY_W  = 3;
	localparam int CH_W    = 2;
	localparam int PCNT_W  = 12;
	localparam int OFS_W   = 6;
	localparam int POS_W   = 18;
	localparam int PIDX_W  = 24;
	localparam int FEAT_W  = 16;
	localparam int WORD_W  = 32;
	localparam int PP_W    = 13;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	localparam int DIV_STEPS = DIM_W + 1;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd448;
	localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd448;
	localparam logic [PATCH_W-1:0] RST_PATCH  = 7'd14;
	localparam logic [MERGE_W-1:0] RST_MERGE  = 4'd2;
	localparam logic [COPY_W-1:0]  RST_COPIES = 3'd2;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_PATCH_EDGE      = 3'd2,
		REG_MERGE_FACTOR    = 3'd3,
		REG_TEMPORAL_COPIES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [PATCH_W-1:0] patch_edge;
		logic [MERGE_W-1:0] merge_factor;
		logic [COPY_W-1:0]  temporal_copies;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [PATCH_W-1:0] p;
		logic [COPY_W-1:0]  t;
		logic [DIM_W-1:0]   grid_w;
		logic [DIM_W-1:0]   used_w;
		logic [DIM_W-1:0]   used_h;
		logic [PP_W-1:0]    pp;
		logic [FEAT_W-1:0]  tpp;
	} geo_t;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [PCNT_W-1:0] patch_row;
		logic [OFS_W-1:0]  row_in;
		logic [PCNT_W-1:0] patch_col;
		logic [OFS_W-1:0]  col_in;
	} cnt_t;

	typedef struct packed {
		logic [POS_W-1:0]  col_pos;
		logic [POS_W-1:0]  row_pos;
		logic [PIDX_W-1:0] row_base;
		logic [FEAT_W-1:0] ch_base;
		logic [FEAT_W-1:0] rin_off;
	} rld_t;

	typedef struct packed {
		logic busy;
		logic load;
	} ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [PIDX_W-1:0] pidx;
		logic [FEAT_W-1:0] fbase;
	} ent_t;

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [PATCH_W-1:0] clamp_patch(logic [PATCH_W-1:0] v);
		if (v == '0)
			return PATCH_W'(1);
		if (v > PATCH_W'(MAX_PATCH))
			return PATCH_W'(MAX_PATCH);
		return v;
	endfunction

	function automatic logic [MERGE_W-1:0] clamp_merge(logic [MERGE_W-1:0] v);
		if (v == '0)
			return MERGE_W'(1);
		if (v > MERGE_W'(MERGE_LIMIT))
			return MERGE_W'(MERGE_LIMIT);
		return v;
	endfunction

	function automatic logic [COPY_W-1:0] clamp_copies(logic [COPY_W-1:0] v);
		if (v == '0)
			return COPY_W'(1);
		if (v > COPY_W'(MAX_COPIES))
			return COPY_W'(MAX_COPIES);
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vpr_setup.sv =====
`default_nettype none

module vpr_setup (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vpr_pkg::cfg_t cfg,
	input  wire logic          cfg_wr,
	input  wire vpr_pkg::cnt_t cnt,
	output vpr_pkg::geo_t      geo,
	output vpr_pkg::rld_t      rld,
	output vpr_pkg::ctl_t      ctl
);
	import vpr_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE    = 15'h0001,
		S_DIV_GW  = 15'h0002,
		S_DIV_GH  = 15'h0004,
		S_DIV_UW  = 15'h0008,
		S_DIV_UH  = 15'h0010,
		S_MUL_UW  = 15'h0020,
		S_MUL_UH  = 15'h0040,
		S_MUL_PP  = 15'h0080,
		S_MUL_TPP = 15'h0100,
		S_MUL_CH  = 15'h0200,
		S_MUL_RIN = 15'h0400,
		S_MUL_COL = 15'h0800,
		S_MUL_ROW = 15'h1000,
		S_MUL_RB  = 15'h2000,
		S_LOAD    = 15'h4000
	} state_t;

	localparam int MUL_A_W = FEAT_W;
	localparam int MUL_B_W = DIM_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	state_t state_q;
	logic [STEP_W-1:0] step_q;
	logic [DIM_W:0]    div_rem_q;
	logic [DIM_W-1:0]  div_quo_q;
	logic [DIM_W-1:0]  grid_w_q, grid_h_q, used_w_q, used_h_q;
	logic [PP_W-1:0]   pp_q;
	logic [FEAT_W-1:0] tpp_q;
	rld_t              rld_q;

	logic [DIM_W-1:0]   w, h;
	logic [PATCH_W-1:0] p;
	logic [MERGE_W-1:0] m;
	logic [COPY_W-1:0]  t;
	logic [DIM_W-1:0]   div_num, div_den;
	logic [DIM_W:0]     rem_sh, rem_nx;
	logic [DIM_W-1:0]   quo_sh, quo_nx;
	logic               div_ge, div_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;

	assign w = clamp_dim(cfg.image_width);
	assign h = clamp_dim(cfg.image_height);
	assign p = clamp_patch(cfg.patch_edge);
	assign m = clamp_merge(cfg.merge_factor);
	assign t = clamp_copies(cfg.temporal_copies);

	always_comb begin
		div_num = '0;
		div_den = DIM_W'(1);
		case (state_q)
			S_DIV_GW: begin
				div_num = w;
				div_den = DIM_W'(p);
			end
			S_DIV_GH: begin
				div_num = h;
				div_den = DIM_W'(p);
			end
			S_DIV_UW: begin
				div_num = grid_w_q;
				div_den = DIM_W'(m);
			end
			S_DIV_UH: begin
				div_num = grid_h_q;
				div_den = DIM_W'(m);
			end
			default: begin
				div_num = '0;
				div_den = DIM_W'(1);
			end
		endcase
	end

	// one quotient bit per cycle
	assign rem_sh   = {div_rem_q[DIM_W-1:0], div_quo_q[DIM_W-1]};
	assign quo_sh   = {div_quo_q[DIM_W-2:0], 1'b0};
	assign div_ge   = rem_sh >= {1'b0, div_den};
	assign rem_nx   = div_ge ? (rem_sh - {1'b0, div_den}) : rem_sh;
	assign quo_nx   = quo_sh | DIM_W'(div_ge);
	assign div_done = step_q == STEP_W'(DIV_STEPS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_UW: begin
				mul_a = MUL_A_W'(used_w_q);
				mul_b = MUL_B_W'(m);
			end
			S_MUL_UH: begin
				mul_a = MUL_A_W'(used_h_q);
				mul_b = MUL_B_W'(m);
			end
			S_MUL_PP: begin
				mul_a = MUL_A_W'(p);
				mul_b = MUL_B_W'(p);
			end
			S_MUL_TPP: begin
				mul_a = MUL_A_W'(pp_q);
				mul_b = MUL_B_W'(t);
			end
			S_MUL_CH: begin
				mul_a = tpp_q;
				mul_b = MUL_B_W'(cnt.ch);
			end
			S_MUL_RIN: begin
				mul_a = MUL_A_W'(cnt.row_in);
				mul_b = MUL_B_W'(p);
			end
			S_MUL_COL: begin
				mul_a = MUL_A_W'(cnt.patch_col);
				mul_b = MUL_B_W'(p);
			end
			S_MUL_ROW: begin
				mul_a = MUL_A_W'(cnt.patch_row);
				mul_b = MUL_B_W'(p);
			end
			S_MUL_RB: begin
				mul_a = MUL_A_W'(cnt.patch_row);
				mul_b = grid_w_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_DIV_GW;
			step_q  <= '0;
		end else if (cfg_wr) begin
			state_q <= S_DIV_GW;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_DIV_GW, S_DIV_GH, S_DIV_UW, S_DIV_UH: begin
					if (div_done) begin
						step_q <= '0;
						case (state_q)
							S_DIV_GW: state_q <= S_DIV_GH;
							S_DIV_GH: state_q <= S_DIV_UW;
							S_DIV_UW: state_q <= S_DIV_UH;
							default:  state_q <= S_MUL_UW;
						endcase
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_MUL_UW:  state_q <= S_MUL_UH;
				S_MUL_UH:  state_q <= S_MUL_PP;
				S_MUL_PP:  state_q <= S_MUL_TPP;
				S_MUL_TPP: state_q <= S_MUL_CH;
				S_MUL_CH:  state_q <= S_MUL_RIN;
				S_MUL_RIN: state_q <= S_MUL_COL;
				S_MUL_COL: state_q <= S_MUL_ROW;
				S_MUL_ROW: state_q <= S_MUL_RB;
				S_MUL_RB:  state_q <= S_LOAD;
				S_LOAD:    state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == '0) begin
			div_rem_q <= '0;
			div_quo_q <= div_num;
		end else if (!div_done) begin
			div_rem_q <= rem_nx;
			div_quo_q <= quo_nx;
		end
		case (state_q)
			S_DIV_GW:  if (div_done) grid_w_q <= div_quo_q;
			S_DIV_GH:  if (div_done) grid_h_q <= div_quo_q;
			S_DIV_UW:  if (div_done) used_w_q <= div_quo_q;
			S_DIV_UH:  if (div_done) used_h_q <= div_quo_q;
			S_MUL_UW:  used_w_q <= prod[DIM_W-1:0];
			S_MUL_UH:  used_h_q <= prod[DIM_W-1:0];
			S_MUL_PP:  pp_q <= prod[PP_W-1:0];
			S_MUL_TPP: tpp_q <= prod[FEAT_W-1:0];
			S_MUL_CH:  rld_q.ch_base <= prod[FEAT_W-1:0];
			S_MUL_RIN: rld_q.rin_off <= prod[FEAT_W-1:0];
			S_MUL_COL: rld_q.col_pos <= prod[POS_W-1:0] + POS_W'(cnt.col_in);
			S_MUL_ROW: rld_q.row_pos <= prod[POS_W-1:0] + POS_W'(cnt.row_in);
			S_MUL_RB:  rld_q.row_base <= prod[PIDX_W-1:0];
			default: begin
			end
		endcase
	end

	always_comb begin
		geo.w      = w;
		geo.h      = h;
		geo.p      = p;
		geo.t      = t;
		geo.grid_w = grid_w_q;
		geo.used_w = used_w_q;
		geo.used_h = used_h_q;
		geo.pp     = pp_q;
		geo.tpp    = tpp_q;
	end

	assign rld      = rld_q;
	assign ctl.busy = state_q != S_IDLE;
	assign ctl.load = state_q == S_LOAD;

	a_grid_w_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |->
			(26'(grid_w_q) * 26'(p) <= 26'(w)) &&
			((26'(grid_w_q) + 26'd1) * 26'(p) > 26'(w)))
		else $error("grid width is not the patch quotient of the image width");

endmodule

`default_nettype wire

// ===== hw/rtl/vpr_front.sv =====
`default_nettype none

module vpr_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pixel_valid,
	input  wire logic [vpr_pkg::WORD_W-1:0] pixel_word,
	output logic                            pixel_stall,
	input  wire vpr_pkg::geo_t              geo,
	input  wire vpr_pkg::ctl_t              ctl,
	input  wire vpr_pkg::rld_t              rld,
	output vpr_pkg::cnt_t                   cnt,
	output logic                            push,
	output vpr_pkg::ent_t                   push_ent,
	input  wire logic                       full
);
	import vpr_pkg::*;

	cnt_t cnt_q;
	rld_t trk_q;

	logic accept, hit;
	logic col_end, row_end, cin_end, rin_end, ch_end;

	assign pixel_stall = ctl.busy | full;
	assign accept      = pixel_valid & ~pixel_stall;

	assign hit = ({1'b0, cnt_q.patch_row} < geo.used_h) &&
		({1'b0, cnt_q.patch_col} < geo.used_w) &&
		({1'b0, cnt_q.row_in} < geo.p) &&
		({1'b0, cnt_q.col_in} < geo.p);

	assign push           = accept & hit;
	assign push_ent.word  = pixel_word;
	assign push_ent.pidx  = trk_q.row_base + PIDX_W'(cnt_q.patch_col);
	assign push_ent.fbase = trk_q.ch_base + trk_q.rin_off + FEAT_W'(cnt_q.col_in);

	assign col_end = ({1'b0, trk_q.col_pos} + (POS_W+1)'(1)) >= (POS_W+1)'(geo.w);
	assign row_end = ({1'b0, trk_q.row_pos} + (POS_W+1)'(1)) >= (POS_W+1)'(geo.h);
	assign cin_end = ({1'b0, cnt_q.col_in} + PATCH_W'(1)) >= geo.p;
	assign rin_end = ({1'b0, cnt_q.row_in} + PATCH_W'(1)) >= geo.p;
	assign ch_end  = ({1'b0, cnt_q.ch} + (CH_W+1)'(1)) >= (CH_W+1)'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			trk_q <= '0;
		end else if (ctl.load) begin
			trk_q <= rld;
		end else if (accept) begin
			if (col_end) begin
				cnt_q.col_in    <= '0;
				cnt_q.patch_col <= '0;
				trk_q.col_pos   <= '0;
				if (row_end) begin
					cnt_q.row_in    <= '0;
					cnt_q.patch_row <= '0;
					trk_q.row_pos   <= '0;
					trk_q.row_base  <= '0;
					trk_q.rin_off   <= '0;
					if (ch_end) begin
						cnt_q.ch      <= '0;
						trk_q.ch_base <= '0;
					end else begin
						cnt_q.ch      <= cnt_q.ch + CH_W'(1);
						trk_q.ch_base <= trk_q.ch_base + geo.tpp;
					end
				end else if (rin_end) begin
					cnt_q.row_in    <= '0;
					cnt_q.patch_row <= cnt_q.patch_row + PCNT_W'(1);
					trk_q.rin_off   <= '0;
					trk_q.row_base  <= trk_q.row_base + PIDX_W'(geo.grid_w);
					trk_q.row_pos   <= trk_q.row_pos - POS_W'(cnt_q.row_in) + POS_W'(geo.p);
				end else begin
					cnt_q.row_in  <= cnt_q.row_in + OFS_W'(1);
					trk_q.rin_off <= trk_q.rin_off + FEAT_W'(geo.p);
					trk_q.row_pos <= trk_q.row_pos + POS_W'(1);
				end
			end else if (cin_end) begin
				cnt_q.col_in    <= '0;
				cnt_q.patch_col <= cnt_q.patch_col + PCNT_W'(1);
				trk_q.col_pos   <= trk_q.col_pos - POS_W'(cnt_q.col_in) + POS_W'(geo.p);
			end else begin
				cnt_q.col_in  <= cnt_q.col_in + OFS_W'(1);
				trk_q.col_pos <= trk_q.col_pos + POS_W'(1);
			end
		end
	end

	assign cnt = cnt_q;

	a_col_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.busy |->
			trk_q.col_pos == POS_W'(cnt_q.patch_col) * POS_W'(geo.p) + POS_W'(cnt_q.col_in))
		else $error("column position out of step with patch counters");

endmodule

`default_nettype wire

// ===== hw/rtl/vpr_fifo.sv =====
`default_nettype none

module vpr_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vpr_pkg::ent_t push_ent,
	input  wire logic          pop,
	output vpr_pkg::ent_t      head,
	output logic               empty,
	output logic               full
);
	import vpr_pkg::*;

	ent_t             entries_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (PTR_W+1)'(FIFO_DEPTH);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PTR_W+1)'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("item popped from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/vpr_back.sv =====
`default_nettype none

module vpr_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire vpr_pkg::ent_t              head,
	input  wire logic                       empty,
	output logic                            pop,
	input  wire vpr_pkg::geo_t              geo,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [vpr_pkg::WORD_W-1:0]      out_word,
	output logic [vpr_pkg::PIDX_W-1:0]      patch_index,
	output logic [vpr_pkg::FEAT_W-1:0]      feature_index,
	output logic                            last_copy
);
	import vpr_pkg::*;

	logic [COPY_W-2:0] k_q;
	logic [FEAT_W-1:0] off_q;
	logic              valid_q;
	logic [WORD_W-1:0] word_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [FEAT_W-1:0] feat_q;
	logic              last_q;

	logic advance, issue, is_last;

	assign advance = ~valid_q | ~result_stall;
	assign issue   = advance & ~empty;
	assign is_last = ({1'b0, k_q} + COPY_W'(1)) == geo.t;
	assign pop     = issue & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
			off_q   <= '0;
		end else begin
			if (advance)
				valid_q <= ~empty;
			if (issue) begin
				if (is_last) begin
					k_q   <= '0;
					off_q <= '0;
				end else begin
					k_q   <= k_q + (COPY_W-1)'(1);
					off_q <= off_q + FEAT_W'(geo.pp);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			word_q <= head.word;
			pidx_q <= head.pidx;
			feat_q <= head.fbase + off_q;
			last_q <= is_last;
		end
	end

	assign result_valid  = valid_q;
	assign out_word      = word_q;
	assign patch_index   = pidx_q;
	assign feature_index = feat_q;
	assign last_copy     = last_q;

	a_copy_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, k_q} < geo.t)
		else $error("copy counter reached the copy count");

	a_pop_shows_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result_valid && last_copy)
		else $error("queue entry retired without its last copy");

endmodule

`default_nettype wire

// ===== hw/rtl/vision_patch_reorder.sv =====
`default_nettype none

// channel  direction  handshake              payload
// pixel    in         pixel_valid/stall      pixel_word[31:0]
// result   out        result_valid/stall     out_word, patch_index, feature_index, last_copy
// apb      in         psel/penable/pready    paddr[4:0], pwdata, prdata (regs at 4*i)
//
// A pixel inside the merge area yields temporal_copies items, one per cycle from the
// output register while result_stall is low; a pixel outside it yields none. A
// four-entry queue between the counters and the copy expander lets a new pixel enter
// while copies drain. After reset and after every register write, the geometry unit
// runs four 13-step divisions and nine multiplies; pixel_stall is high throughout.
// result_stall holds the output register; pixel_stall rises when the queue is full.
module vision_patch_reorder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pixel_valid,
	output logic                            pixel_stall,
	input  wire logic [vpr_pkg::WORD_W-1:0] pixel_word,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [vpr_pkg::WORD_W-1:0]      out_word,
	output logic [vpr_pkg::PIDX_W-1:0]      patch_index,
	output logic [vpr_pkg::FEAT_W-1:0]      feature_index,
	output logic                            last_copy,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vpr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [vpr_pkg::DATA_W-1:0] pwdata,
	output logic [vpr_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import vpr_pkg::*;

	cfg_t cfg_q;
	geo_t geo;
	rld_t rld;
	ctl_t ctl;
	cnt_t cnt;
	ent_t push_ent, head;

	logic       cfg_wr;
	logic [2:0] reg_idx;
	logic       push, pop, empty, full;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_WIDTH;
			cfg_q.image_height    <= RST_HEIGHT;
			cfg_q.patch_edge      <= RST_PATCH;
			cfg_q.merge_factor    <= RST_MERGE;
			cfg_q.temporal_copies <= RST_COPIES;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[DIM_W-1:0];
				REG_PATCH_EDGE:      cfg_q.patch_edge      <= pwdata[PATCH_W-1:0];
				REG_MERGE_FACTOR:    cfg_q.merge_factor    <= pwdata[MERGE_W-1:0];
				REG_TEMPORAL_COPIES: cfg_q.temporal_copies <= pwdata[COPY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:     prdata = DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:    prdata = DATA_W'(cfg_q.image_height);
			REG_PATCH_EDGE:      prdata = DATA_W'(cfg_q.patch_edge);
			REG_MERGE_FACTOR:    prdata = DATA_W'(cfg_q.merge_factor);
			REG_TEMPORAL_COPIES: prdata = DATA_W'(cfg_q.temporal_copies);
			default:             prdata = '0;
		endcase
	end

	vpr_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cfg_wr (cfg_wr),
		.cnt    (cnt),
		.geo    (geo),
		.rld    (rld),
		.ctl    (ctl)
	);

	vpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_word  (pixel_word),
		.pixel_stall (pixel_stall),
		.geo         (geo),
		.ctl         (ctl),
		.rld         (rld),
		.cnt         (cnt),
		.push        (push),
		.push_ent    (push_ent),
		.full        (full)
	);

	vpr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	vpr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.geo           (geo),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_word      (out_word),
		.patch_index   (patch_index),
		.feature_index (feature_index),
		.last_copy     (last_copy)
	);

endmodule

`default_nettype wire

// ===== test/tb_vision_patch_reorder.sv =====
module tb_vision_patch_reorder;
	timeunit 1ns;
	timeprecision 1ps;

	import vpr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS  = 470;
	localparam int MAX_SHOWN     = 10;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [PIDX_W-1:0] pidx;
		logic [FEAT_W-1:0] feat;
		logic              last;
	} copy_item_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                pixel_valid   = 1'b0;
	logic                pixel_stall;
	logic [WORD_W-1:0]   pixel_word    = '0;
	logic                result_valid;
	logic                result_stall  = 1'b0;
	logic [WORD_W-1:0]   out_word;
	logic [PIDX_W-1:0]   patch_index;
	logic [FEAT_W-1:0]   feature_index;
	logic                last_copy;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [ADDR_W-1:0]   paddr         = '0;
	logic [DATA_W-1:0]   pwdata        = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// shadow registers and scan counters
	logic [DIM_W-1:0]    cfg_width     = RST_WIDTH;
	logic [DIM_W-1:0]    cfg_height    = RST_HEIGHT;
	logic [PATCH_W-1:0]  cfg_patch     = RST_PATCH;
	logic [MERGE_W-1:0]  cfg_merge     = RST_MERGE;
	logic [COPY_W-1:0]   cfg_copies    = RST_COPIES;
	logic [CH_W-1:0]     ch            = '0;
	logic [PCNT_W-1:0]   prow          = '0;
	logic [OFS_W-1:0]    rin           = '0;
	logic [PCNT_W-1:0]   pcol          = '0;
	logic [OFS_W-1:0]    cin           = '0;

	logic [WORD_W-1:0]   pixel_q[$];
	copy_item_t          copy_q[$];
	logic                pix_taken     = 1'b0;
	logic                res_taken     = 1'b0;
	int unsigned         pix_gap       = 0;
	int unsigned         res_wait      = 0;
	bit                  pix_burst     = 1'b0;
	bit                  res_burst     = 1'b0;
	int                  mismatches    = 0;
	int unsigned         cycle_cnt     = 0;

	vision_patch_reorder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.pixel_word    (pixel_word),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_word      (out_word),
		.patch_index   (patch_index),
		.feature_index (feature_index),
		.last_copy     (last_copy),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic int unsigned draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 19);
	endfunction

	// expected copies of one pixel, then advance the scan counters
	task automatic scatter_pixel(input logic [WORD_W-1:0] word);
		int unsigned w, h, p, m, t, gw, uw, uh, pp, pidx, cpos, rpos;
		copy_item_t c;
		w  = clip(cfg_width, MAX_DIM);
		h  = clip(cfg_height, MAX_DIM);
		p  = clip(cfg_patch, MAX_PATCH);
		m  = clip(cfg_merge, MERGE_LIMIT);
		t  = clip(cfg_copies, MAX_COPIES);
		gw = w / p;
		uw = (gw / m) * m;
		uh = ((h / p) / m) * m;
		if (prow < uh && pcol < uw && rin < p && cin < p) begin
			pp   = p * p;
			pidx = prow * gw + pcol;
			for (int unsigned k = 0; k < t; k++) begin
				c.word = word;
				c.pidx = PIDX_W'(pidx);
				c.feat = FEAT_W'(ch * t * pp + k * pp + rin * p + cin);
				c.last = (k + 1 == t);
				copy_q.push_back(c);
			end
		end
		cpos = pcol * p + cin;
		if (cpos + 1 >= w) begin
			cin  = '0;
			pcol = '0;
			rpos = prow * p + rin;
			if (rpos + 1 >= h) begin
				rin  = '0;
				prow = '0;
				ch   = (ch + 1 >= CHANNELS) ? '0 : CH_W'(ch + 1);
			end else if (rin + 1 >= p) begin
				rin  = '0;
				prow = prow + 1'b1;
			end else begin
				rin = rin + 1'b1;
			end
		end else if (cin + 1 >= p) begin
			cin  = '0;
			pcol = pcol + 1'b1;
		end else begin
			cin = cin + 1'b1;
		end
	endtask

	task automatic check_copy();
		copy_item_t want;
		if (copy_q.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("unexpected item: word %h patch %0d feature %0d last %b",
					out_word, patch_index, feature_index, last_copy);
		end else begin
			want = copy_q.pop_front();
			if (out_word !== want.word || patch_index !== want.pidx ||
				feature_index !== want.feat || last_copy !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("mismatch: exp word %h patch %0d feature %0d last %b / %s",
						want.word, want.pidx, want.feat, want.last,
						$sformatf("got word %h patch %0d feature %0d last %b",
						out_word, patch_index, feature_index, last_copy));
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		pix_taken <= arst_n && pixel_valid && !pixel_stall;
		res_taken <= arst_n && result_valid && !result_stall;
		if (arst_n && result_valid && !result_stall)
			check_copy();
		if (arst_n && pixel_valid && !pixel_stall)
			scatter_pixel(pixel_word);
	end

	// pixel driver
	always @(negedge clk) begin
		if (arst_n && (!pixel_valid || pix_taken)) begin
			if (pix_gap != 0) begin
				pixel_valid <= 1'b0;
				pix_gap = pix_gap - 1;
			end else if (pixel_q.size() != 0) begin
				pixel_word  <= pixel_q.pop_front();
				pixel_valid <= 1'b1;
				if ($urandom_range(0, 15) == 0)
					pix_burst = !pix_burst;
				pix_gap = draw_gap(pix_burst);
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// result stall driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				if ($urandom_range(0, 15) == 0)
					res_burst = !res_burst;
				res_wait = draw_gap(res_burst);
			end
			if (res_wait != 0) begin
				result_stall <= 1'b1;
				res_wait = res_wait - 1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:     cfg_width  = DIM_W'(value);
			REG_IMAGE_HEIGHT:    cfg_height = DIM_W'(value);
			REG_PATCH_EDGE:      cfg_patch  = PATCH_W'(value);
			REG_MERGE_FACTOR:    cfg_merge  = MERGE_W'(value);
			REG_TEMPORAL_COPIES: cfg_copies = COPY_W'(value);
			default: ;
		endcase
	endtask

	// sampled at the rising edge, where the driver's last update has settled
	task automatic wait_idle();
		@(posedge clk);
		while (pixel_q.size() != 0 || pixel_valid || copy_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h, input int unsigned p,
		input int unsigned m, input int unsigned t);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_PATCH_EDGE, p);
		write_reg(REG_MERGE_FACTOR, m);
		write_reg(REG_TEMPORAL_COPIES, t);
	endtask

	task automatic feed_random(input int unsigned n);
		repeat (n) pixel_q.push_back($urandom);
	endtask

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned sel, n, sent;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry, word extremes
		pixel_q.push_back(32'h0000_0000);
		pixel_q.push_back(32'hFFFF_FFFF);
		pixel_q.push_back(32'h8000_0000);
		pixel_q.push_back(32'h7FFF_FFFF);

		// all registers zero: every pixel is its own image and channel
		configure(0, 0, 0, 0, 0);
		pixel_q.push_back(32'h7F80_0000);
		pixel_q.push_back(32'hFF80_0000);
		pixel_q.push_back(32'h0000_0001);
		pixel_q.push_back(32'hAAAA_5555);

		// saturating values
		configure(8191, 8191, 127, 15, 7);
		feed_random(4);

		// partial patches on the right and bottom edge
		configure(3, 3, 2, 1, 3);
		feed_random(10);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 11);
			if (sel == 0) begin
				configure($urandom_range(4096, 8191), $urandom_range(1, 8191),
					$urandom_range(64, 127), $urandom_range(8, 15), $urandom_range(4, 7));
				n = $urandom_range(5, 15);
			end else if (sel == 1) begin
				configure($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 2),
					$urandom_range(0, 2), $urandom_range(0, 4));
				n = $urandom_range(20, 40);
			end else begin
				configure($urandom_range(1, 24), $urandom_range(1, 10), $urandom_range(1, 6),
					$urandom_range(1, 3), $urandom_range(1, 4));
				n = $urandom_range(20, 60);
			end
			feed_random(n);
			sent += n;
		end

		wait_idle();
		if (mismatches == 0 && copy_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/vpr_pkg.sv
hw/rtl/vpr_setup.sv
hw/rtl/vpr_front.sv
hw/rtl/vpr_fifo.sv
hw/rtl/vpr_back.sv
hw/rtl/vision_patch_reorder.sv
test/tb_vision_patch_reorder.sv
